### hw/rtl/olrb_pkg.sv
// ----------------------------------------------------------------------------
// olrb_pkg
// Shared types and operation codes for the overwriting log ring buffer.
// ----------------------------------------------------------------------------
package olrb_pkg;

    // Operation codes carried on the func field
    localparam logic [1:0] FUNC_PUT    = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_SNAP   = 2'd2;
    localparam logic [1:0] FUNC_REWIND = 2'd3;

    localparam int unsigned BYTE_W = 8;

    // Result flags passed from the pointer controller to the result pipe
    typedef struct packed {
        logic got;
        logic dropped;
    } olrb_flags_t;

endpackage

### hw/rtl/olrb_ram.sv
// ----------------------------------------------------------------------------
// olrb_ram
// Generic single-clock RAM, one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module olrb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write on enable, hold read data until the next read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/olrb_ctrl.sv
// ----------------------------------------------------------------------------
// olrb_ctrl
// Ring pointer controller: holds write, read and snapshot pointers, decodes
// each accepted transaction into RAM accesses and result flags.
// ----------------------------------------------------------------------------
module olrb_ctrl
    import olrb_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  logic [1:0]               func,
    output logic                     wr_en,
    output logic [$clog2(DEPTH)-1:0] wr_addr,
    output logic                     rd_en,
    output logic [$clog2(DEPTH)-1:0] rd_addr,
    output olrb_flags_t              flags
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] sp_reg, sp_next;
    logic [AW-1:0] wp_inc, rp_inc, sp_inc;
    logic          full;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        ring_next = (p == LAST) ? '0 : p + AW'(1);
    endfunction

    assign wp_inc  = ring_next(wp_reg);
    assign rp_inc  = ring_next(rp_reg);
    assign sp_inc  = ring_next(sp_reg);
    assign full    = (wp_inc == rp_reg);

    // Decode one transaction into pointer moves and RAM accesses
    always_comb begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        sp_next       = sp_reg;
        wr_en         = 1'b0;
        wr_addr       = wp_reg;
        rd_en         = 1'b0;
        rd_addr       = rp_reg;
        flags.got     = 1'b0;
        flags.dropped = 1'b0;
        unique case (func)
            FUNC_PUT: begin
                wr_en   = accept;
                wp_next = wp_inc;
                if (full) begin
                    // Drop the oldest byte, drag the snapshot cursor along if it sat on it
                    rp_next       = rp_inc;
                    flags.dropped = 1'b1;
                    if (sp_inc == rp_inc) begin
                        sp_next = rp_inc;
                    end
                end
            end
            FUNC_POP: begin
                if (rp_reg != wp_reg) begin
                    rd_en     = accept;
                    flags.got = 1'b1;
                    rp_next   = rp_inc;
                end
            end
            FUNC_SNAP: begin
                rd_addr = sp_reg;
                if (sp_reg != wp_reg) begin
                    rd_en     = accept;
                    flags.got = 1'b1;
                    sp_next   = sp_inc;
                end
            end
            FUNC_REWIND: begin
                sp_next = rp_reg;
            end
            default: begin
                sp_next = sp_reg;
            end
        endcase
    end

    // Advance pointers on an accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            sp_reg <= '0;
        end else if (accept) begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            sp_reg <= sp_next;
        end
    end

endmodule

### hw/rtl/overwriting_log_ring_buffer.sv
// ----------------------------------------------------------------------------
// overwriting_log_ring_buffer
// Byte log ring that keeps its newest bytes, with a consuming read pointer
// and a non-consuming snapshot cursor.
// ----------------------------------------------------------------------------
// An accepted transaction reads the RAM into the registered read data beside
// the stage slot, then moves on into the output register when it is free.
// Throughput: one transaction per cycle while the output is not stalled, set
// by the single RAM read port feeding a two-stage result pipe.
// Reset clears the write, read and snapshot pointers and the pipe; the byte
// store is not cleared and needs no clearing pass.
module overwriting_log_ring_buffer
    import olrb_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_func,
    input  logic [BYTE_W-1:0] s_data_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_data_out,
    output logic              m_got_byte,
    output logic              m_dropped_oldest
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic              accept;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [BYTE_W-1:0] rd_data;
    olrb_flags_t       flags;

    logic              stage_v_reg, stage_v_next;
    olrb_flags_t       stage_flags_reg;
    logic              out_v_reg, out_v_next;
    logic [BYTE_W-1:0] out_data_reg;
    olrb_flags_t       out_flags_reg;
    logic              advance;

    // Move the stage forward when the output slot is free or being taken
    assign advance = stage_v_reg && (!out_v_reg || m_ready);
    assign s_ready = !stage_v_reg || advance;
    assign accept  = s_valid && s_ready;

    olrb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .func    (s_func),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .flags   (flags)
    );

    olrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        stage_v_next = accept ? 1'b1 : (advance ? 1'b0 : stage_v_reg);
        out_v_next   = advance ? 1'b1 : (m_ready ? 1'b0 : out_v_reg);
    end

    // Control state of the result pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_v_reg <= 1'b0;
            out_v_reg   <= 1'b0;
        end else begin
            stage_v_reg <= stage_v_next;
            out_v_reg   <= out_v_next;
        end
    end

    // Payload of the result pipe; zero the data of a transaction without a byte
    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_flags_reg <= flags;
        end
        if (advance) begin
            out_flags_reg <= stage_flags_reg;
            out_data_reg  <= stage_flags_reg.got ? rd_data : '0;
        end
    end

    assign m_valid          = out_v_reg;
    assign m_data_out       = out_data_reg;
    assign m_got_byte       = out_flags_reg.got;
    assign m_dropped_oldest = out_flags_reg.dropped;

    // A result never both returns a byte and reports a drop
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_got_byte && m_dropped_oldest))
        else $error("result both returned a byte and dropped one");

    // An empty read or a put always returns zero data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_got_byte) |-> (m_data_out == '0))
        else $error("nonzero data without a byte");

    // A full pipe with a stalled output takes no new transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_v_reg && out_v_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while the pipe is full");

    // A taken stage always lands in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("stage advanced without filling the output");

endmodule

### sim/tb_overwriting_log_ring_buffer.sv
// ----------------------------------------------------------------------------
// tb_overwriting_log_ring_buffer
// Self-checking bench for the overwriting log ring buffer. A short table of
// directed transactions covers empty reads, a lagging snapshot cursor and the
// data extremes. Random traffic then builds a deep backlog in the ring and
// churns it with pops, snapshot reads and rewinds. Every reply is checked
// field by field against its typed table reply or the in-bench ring model.
// Both sides idle at random; the receiver once holds off long enough to stall input.
// ----------------------------------------------------------------------------
module tb_overwriting_log_ring_buffer
    import olrb_pkg::*;
();

    localparam int unsigned RING_DEPTH     = 1024;
    localparam int          HOLD_OFF_LEN   = 300;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          TAIL_CYCLES    = 10;
    localparam int          MIX_ITEMS      = 100;
    localparam int          FILL_ITEMS     = 375;
    localparam int          CHURN_ITEMS    = 100;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              got;
        logic              dropped;
    } ring_reply_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [BYTE_W-1:0] b;
        logic              typed;
        ring_reply_t       reply;
    } directed_row_t;

    localparam ring_reply_t NO_BYTE = '{8'h00, 1'b0, 1'b0};

    // Directed rows; typed replies follow from the pointer walk in the comments
    localparam directed_row_t DIRECTED_ROWS [25] = '{
        '{FUNC_POP,    8'h00, 1'b1, NO_BYTE},               // pop on empty ring
        '{FUNC_SNAP,   8'h00, 1'b1, NO_BYTE},               // snapshot at end
        '{FUNC_REWIND, 8'h00, 1'b1, NO_BYTE},
        '{FUNC_PUT,    8'h00, 1'b1, NO_BYTE},               // slot 0
        '{FUNC_PUT,    8'hFF, 1'b1, NO_BYTE},               // slot 1
        '{FUNC_POP,    8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{FUNC_SNAP,   8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},  // cursor lags read
        '{FUNC_SNAP,   8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0}},
        '{FUNC_SNAP,   8'h00, 1'b1, NO_BYTE},
        '{FUNC_REWIND, 8'h00, 1'b1, NO_BYTE},               // cursor to slot 1
        '{FUNC_SNAP,   8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0}},
        '{FUNC_POP,    8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0}},
        '{FUNC_POP,    8'h00, 1'b1, NO_BYTE},
        '{FUNC_PUT,    8'h80, 1'b1, NO_BYTE},               // slot 2
        '{FUNC_PUT,    8'h01, 1'b1, NO_BYTE},               // slot 3
        '{FUNC_PUT,    8'h7F, 1'b1, NO_BYTE},               // slot 4
        '{FUNC_POP,    8'hAA, 1'b1, '{8'h80, 1'b1, 1'b0}},  // data ignored
        '{FUNC_SNAP,   8'hFF, 1'b1, '{8'h80, 1'b1, 1'b0}},
        '{FUNC_REWIND, 8'hFF, 1'b1, NO_BYTE},
        '{FUNC_SNAP,   8'h00, 1'b1, '{8'h01, 1'b1, 1'b0}},
        '{FUNC_POP,    8'h00, 1'b1, '{8'h01, 1'b1, 1'b0}},
        '{FUNC_POP,    8'h00, 1'b1, '{8'h7F, 1'b1, 1'b0}},
        '{FUNC_SNAP,   8'h00, 1'b1, '{8'h7F, 1'b1, 1'b0}},
        '{FUNC_PUT,    8'h55, 1'b0, NO_BYTE},
        '{FUNC_PUT,    8'hAA, 1'b0, NO_BYTE}
    };

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_func;
    logic [BYTE_W-1:0] s_data_in;
    logic              m_valid;
    logic              m_ready;
    logic [BYTE_W-1:0] m_data_out;
    logic              m_got_byte;
    logic              m_dropped_oldest;

    // Model of the ring
    logic [BYTE_W-1:0] logged_bytes [RING_DEPTH];
    int unsigned       wr_idx;
    int unsigned       rd_idx;
    int unsigned       snap_idx;

    ring_reply_t       pending_replies [$];
    logic              row_typed;
    ring_reply_t       row_reply;
    bit                idling_on;
    bit                hold_off_req;
    int                idle_cycles;
    int                errors;

    overwriting_log_ring_buffer #(
        .DEPTH(RING_DEPTH)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_data_in       (s_data_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_out      (m_data_out),
        .m_got_byte      (m_got_byte),
        .m_dropped_oldest(m_dropped_oldest)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one operation to the model and return its reply
    function automatic ring_reply_t ring_reply_for(logic [1:0] op, logic [BYTE_W-1:0] b);
        ring_reply_t rep;
        rep = NO_BYTE;
        case (op)
            FUNC_PUT: begin
                // Full ring: drop the oldest byte, drag the cursor if it sat on it
                if ((wr_idx + 1) % RING_DEPTH == rd_idx) begin
                    rd_idx = (rd_idx + 1) % RING_DEPTH;
                    if ((snap_idx + 1) % RING_DEPTH == rd_idx)
                        snap_idx = rd_idx;
                    rep.dropped = 1'b1;
                end
                logged_bytes[wr_idx] = b;
                wr_idx = (wr_idx + 1) % RING_DEPTH;
            end
            FUNC_POP: begin
                if (rd_idx != wr_idx) begin
                    rep.data = logged_bytes[rd_idx];
                    rep.got  = 1'b1;
                    rd_idx   = (rd_idx + 1) % RING_DEPTH;
                end
            end
            FUNC_SNAP: begin
                if (snap_idx != wr_idx) begin
                    rep.data = logged_bytes[snap_idx];
                    rep.got  = 1'b1;
                    snap_idx = (snap_idx + 1) % RING_DEPTH;
                end
            end
            FUNC_REWIND: begin
                snap_idx = rd_idx;
            end
            default: ;
        endcase
        return rep;
    endfunction

    // Mostly back to back, sometimes a few cycles, rarely a long pause
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idling_on || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [1:0] pick_func(int w_put, int w_pop, int w_snap, int w_rew);
        int r;
        r = $urandom_range(0, w_put + w_pop + w_snap + w_rew - 1);
        if (r < w_put)
            return FUNC_PUT;
        else if (r < w_put + w_pop)
            return FUNC_POP;
        else if (r < w_put + w_pop + w_snap)
            return FUNC_SNAP;
        else
            return FUNC_REWIND;
    endfunction

    // Offer one transaction and hold it until accepted; call right after a posedge
    task automatic send_op(logic [1:0] op, logic [BYTE_W-1:0] b, logic typed,
                           ring_reply_t reply);
        int gap;
        gap = gap_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) begin
                s_func    = 2'($urandom);
                s_data_in = 8'($urandom);
                @(negedge aclk);
            end
        end
        s_valid   = 1'b1;
        s_func    = op;
        s_data_in = b;
        row_typed = typed;
        row_reply = reply;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Sample both channels: check replies, then record newly accepted transactions
    always @(posedge aclk) begin : monitor
        ring_reply_t oldest;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    errors++;
                    $display("%0t: reply with no transaction outstanding", $time);
                end else begin
                    oldest = pending_replies.pop_front();
                    if (m_data_out !== oldest.data) begin
                        errors++;
                        $display("%0t: data_out expected %02h, got %02h",
                                 $time, oldest.data, m_data_out);
                    end
                    if (m_got_byte !== oldest.got) begin
                        errors++;
                        $display("%0t: got_byte expected %0b, got %0b",
                                 $time, oldest.got, m_got_byte);
                    end
                    if (m_dropped_oldest !== oldest.dropped) begin
                        errors++;
                        $display("%0t: dropped_oldest expected %0b, got %0b",
                                 $time, oldest.dropped, m_dropped_oldest);
                    end
                end
            end
            if (s_valid && s_ready) begin
                oldest = ring_reply_for(s_func, s_data_in);
                pending_replies.push_back(row_typed ? row_reply : oldest);
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready = 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            stall = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int          i;
        logic [1:0]  op;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_func       = FUNC_PUT;
        s_data_in    = '0;
        row_typed    = 1'b0;
        row_reply    = NO_BYTE;
        idling_on    = 1'b1;
        hold_off_req = 1'b0;
        idle_cycles  = 0;
        errors       = 0;
        wr_idx       = 0;
        rd_idx       = 0;
        snap_idx     = 0;

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // Walk the directed table
        for (i = 0; i < 25; i++)
            send_op(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].typed,
                    DIRECTED_ROWS[i].reply);

        // Mixed traffic around an almost empty ring
        for (i = 0; i < MIX_ITEMS; i++) begin
            op = pick_func(40, 25, 25, 10);
            send_op(op, 8'($urandom), 1'b0, NO_BYTE);
        end

        // Build a deep backlog; first half without idling on either side
        idling_on = 1'b0;
        for (i = 0; i < FILL_ITEMS; i++) begin
            if (i == FILL_ITEMS / 2)
                idling_on = 1'b1;
            op = pick_func(95, 0, 3, 2);
            send_op(op, 8'($urandom), 1'b0, NO_BYTE);
        end

        // Churn the backlog: pops, rewinds and snapshot reads far behind the writes
        hold_off_req = 1'b1;
        for (i = 0; i < CHURN_ITEMS; i++) begin
            op = pick_func(45, 15, 25, 15);
            send_op(op, 8'($urandom), 1'b0, NO_BYTE);
        end

        // Drain and let any stray reply show up
        @(negedge aclk);
        s_valid   = 1'b0;
        idling_on = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
